### hw/rtl/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and constants for the card number Luhn classifier
// Holds field widths, decimal conversion sizing, brand codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

  // Width of the card number field; the working binary shift register is BinWidth.
  localparam int NumberWidth = 63;
  // Bits consumed by one pass of the shift-and-add-3 conversion unit.
  localparam int StepBits    = 4;
  // Binary register rounded up to a whole number of conversion passes.
  localparam int BinWidth    = ((NumberWidth + StepBits - 1) / StepBits) * StepBits;
  localparam int ConvSteps   = BinWidth / StepBits;
  localparam int ConvCntWidth = $clog2(ConvSteps);

  // A 63-bit value has at most 19 decimal digits.
  localparam int DigitCount  = 19;
  localparam int BcdWidth    = 4 * DigitCount;
  localparam int ScanIdxWidth = $clog2(DigitCount);

  localparam int CountWidth  = 5;
  localparam int BrandWidth  = 2;

  localparam int InDataWidth  = ((NumberWidth + 7) / 8) * 8;
  localparam int OutDataWidth = 8;

  // Length limits of a card number.
  localparam logic [CountWidth-1:0] MinLen   = 5'd13;
  localparam logic [CountWidth-1:0] AmexLen  = 5'd15;
  localparam logic [CountWidth-1:0] CardLen16 = 5'd16;
  localparam logic [CountWidth-1:0] VisaLen13 = 5'd13;

  typedef enum logic [BrandWidth-1:0] {
    BRAND_INVALID    = 2'd0,
    BRAND_AMEX       = 2'd1,
    BRAND_MASTERCARD = 2'd2,
    BRAND_VISA       = 2'd3
  } brand_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/cnlc_dabble.sv
// ----------------------------------------------------------------------------
// cnlc_dabble: shift-and-add-3 binary to BCD conversion unit
// Shifts StepBits binary bits, most significant first, into a packed BCD
// accumulator, adjusting every digit before each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_dabble (
  input  logic [cnlc_pkg::BcdWidth-1:0] bcd_in,
  input  logic [cnlc_pkg::StepBits-1:0] bits,
  output logic [cnlc_pkg::BcdWidth-1:0] bcd_out
);
  import cnlc_pkg::*;

  always_comb begin
    logic [BcdWidth-1:0] acc;
    acc = bcd_in;
    for (int s = StepBits - 1; s >= 0; s--) begin
      // A digit of 5 or more would exceed 9 after doubling, so pre-add 3.
      for (int k = 0; k < DigitCount; k++) begin
        if (acc[4*k +: 4] >= 4'd5) begin
          acc[4*k +: 4] = acc[4*k +: 4] + 4'd3;
        end
      end
      acc = {acc[BcdWidth-2:0], bits[s]};
    end
    bcd_out = acc;
  end

endmodule

`default_nettype wire

### hw/rtl/card_number_luhn_classify_unit.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classify_unit: Luhn mod-10 check and card brand decode
// Converts a binary card number to decimal, checks the Luhn sum and the
// digit count, and reports the card brand.
// ----------------------------------------------------------------------------
// The unit takes one card number per input transaction and returns exactly
// one result transaction carrying the brand, the Luhn check flag and the
// number of decimal digits. The number is first turned into 19 BCD digits
// by a shift-and-add-3 unit that consumes the 64-bit padded value four
// binary bits per cycle. A second pass then walks the BCD digits from the
// least significant end, one digit per cycle, doubling every second digit,
// folding values above 9, keeping the running sum modulo ten, and
// remembering the position and the top two digits of the most significant
// non-zero digit. The result state then decodes the brand and loads the
// output register. s_tready is low from the accepted input until the result
// is registered. The next input can be accepted in the cycle after the
// result is registered. The output register lets the next item be accepted
// while the previous result still waits for m_tready; if a result is still
// waiting when the next one finishes, the unit holds the new one until the
// output register frees up, and that wait delays the next input. A zero
// input yields digit count 0, checksum flag 1 and brand invalid.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classify_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream. s_tdata bits from the lowest: number[62:0], one zero pad bit.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cnlc_pkg::InDataWidth-1:0]   s_tdata,
  // Result stream. m_tdata bits from the lowest: brand[1:0], checksum_ok,
  // digit_count[4:0].
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cnlc_pkg::OutDataWidth-1:0]  m_tdata
);
  import cnlc_pkg::*;

  state_t state;
  state_t state_next;

  // Conversion and scan datapath registers.
  logic [BinWidth-1:0]     bin;
  logic [BcdWidth-1:0]     bcd;
  logic [ConvCntWidth-1:0] conv_cnt;
  logic [ScanIdxWidth-1:0] scan_idx;
  logic [3:0]              sum;
  logic [CountWidth-1:0]   count;
  logic [3:0]              lead_hi;
  logic [3:0]              lead_lo;
  logic [3:0]              prev_digit;

  logic [BcdWidth-1:0]     bcd_conv;

  // Per-digit scan logic.
  logic [3:0]              digit;
  logic [4:0]              dbl;
  logic [3:0]              digit_val;
  logic [4:0]              sum_add;
  logic [3:0]              sum_next;

  // Result decode.
  logic                    luhn_ok;
  logic                    len_ok;
  brand_t                  brand;
  logic                    out_load;

  logic                    accept;
  logic                    conv_last;
  logic                    scan_last;

  cnlc_dabble u_dabble (
    .bcd_in  (bcd),
    .bits    (bin[BinWidth-1 -: StepBits]),
    .bcd_out (bcd_conv)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign conv_last = (conv_cnt == ConvCntWidth'(ConvSteps - 1));
  assign scan_last = (scan_idx == ScanIdxWidth'(DigitCount - 1));
  assign out_load  = (state == ST_RESULT) && (!m_tvalid || m_tready);

  // Digits at odd positions, counted from the least significant one, are
  // doubled and folded back below ten.
  assign digit = bcd[3:0];
  always_comb begin
    dbl = {digit, 1'b0};
    if (scan_idx[0]) begin
      digit_val = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end else begin
      digit_val = digit;
    end
    sum_add  = {1'b0, sum} + {1'b0, digit_val};
    sum_next = (sum_add >= 5'd10) ? 4'(sum_add - 5'd10) : sum_add[3:0];
  end

  // Brand decode from the Luhn sum, the length and the two leading digits.
  always_comb begin
    luhn_ok = (sum == 4'd0);
    len_ok  = (count >= MinLen);
    brand   = BRAND_INVALID;
    if (luhn_ok && len_ok) begin
      if (count == AmexLen && lead_hi == 4'd3 && (lead_lo == 4'd4 || lead_lo == 4'd7)) begin
        brand = BRAND_AMEX;
      end else if (count == CardLen16 && lead_hi == 4'd5 &&
                   lead_lo >= 4'd1 && lead_lo <= 4'd5) begin
        brand = BRAND_MASTERCARD;
      end else if ((count == VisaLen13 || count == CardLen16) && lead_hi == 4'd4) begin
        brand = BRAND_VISA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (conv_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath registers; they carry no reset since the sequencer loads them
  // before use.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          bin      <= BinWidth'(s_tdata[NumberWidth-1:0]);
          bcd      <= '0;
          conv_cnt <= '0;
        end
      end
      ST_CONVERT: begin
        bcd      <= bcd_conv;
        bin      <= bin << StepBits;
        conv_cnt <= conv_cnt + 1'b1;
        if (conv_last) begin
          scan_idx   <= '0;
          sum        <= '0;
          count      <= '0;
          lead_hi    <= '0;
          lead_lo    <= '0;
          prev_digit <= '0;
        end
      end
      ST_SCAN: begin
        sum        <= sum_next;
        bcd        <= bcd >> 4;
        prev_digit <= digit;
        scan_idx   <= scan_idx + 1'b1;
        // The most significant non-zero digit fixes the length and the lead.
        if (digit != 4'd0) begin
          count   <= CountWidth'(scan_idx) + 1'b1;
          lead_hi <= digit;
          lead_lo <= prev_digit;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {count, luhn_ok, brand};
    end
  end

endmodule

`default_nettype wire
